FILE: rtl/eight_bit_alu_with_flags_macros.svh
// Assertion macros for the eight-bit ALU pipeline
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH
`ifndef SYNTHESIS
`define EBA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eba: same-cycle check failed");
`define EBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eba: next-cycle check failed");
`else
`define EBA_ASSERT_NOW(lbl, ante, cons)
`define EBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/eba_pkg.sv
// Package: command codes, flag positions and DAA constants for the ALU
`timescale 1ns / 1ps
package eba_pkg;

    localparam int CMD_W  = 5;
    localparam int BYTE_W = 8;
    localparam int FLAG_W = 4;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [BYTE_W-1:0] DAA_LIMIT  = 8'h99;
    localparam logic [3:0]        NIBBLE_MAX = 4'h9;
    localparam logic [BYTE_W-1:0] DAA_HI     = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_LO     = 8'h06;
    localparam logic [BYTE_W-1:0] ONE_BYTE   = 8'h01;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 5'd0,
        CMD_ADC  = 5'd1,
        CMD_SUB  = 5'd2,
        CMD_SBC  = 5'd3,
        CMD_AND  = 5'd4,
        CMD_XOR  = 5'd5,
        CMD_OR   = 5'd6,
        CMD_CP   = 5'd7,
        CMD_INC  = 5'd8,
        CMD_DEC  = 5'd9,
        CMD_DAA  = 5'd10,
        CMD_RLCA = 5'd11,
        CMD_RRCA = 5'd12,
        CMD_RLA  = 5'd13,
        CMD_RRA  = 5'd14,
        CMD_CPL  = 5'd15,
        CMD_SCF  = 5'd16,
        CMD_CCF  = 5'd17
    } cmd_t;

endpackage

FILE: rtl/eight_bit_alu_with_flags.sv
// Top level: three-stage accumulator ALU with Z/N/H/C flags
`timescale 1ns / 1ps
// The block accepts one word per cycle while in_stall is low and works
// on it in stages: stage one decodes the command and prepares the adder operands
// (operand inversion for subtracts, DAA correction), stage two runs the
// single shared 8-bit adder with half and full carry, and stage three picks
// the result and flags into the output register. Stall from the output side
// backs up through the stages without losing or repeating a word; empty
// stages fill even while the output waits. Commands outside the list pass
// the accumulator and flags through unchanged.
`include "eight_bit_alu_with_flags_macros.svh"
module eight_bit_alu_with_flags
    import eba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [BYTE_W-1:0]   acc_in,
    input  logic [BYTE_W-1:0]   operand,
    input  logic [FLAG_W-1:0]   flags_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [BYTE_W-1:0]   acc_out,
    output logic [FLAG_W-1:0]   flags_out
);

    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s3_load;

    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    logic [BYTE_W-1:0] s1_a_reg;
    logic [FLAG_W-1:0] s1_f_reg;
    logic [BYTE_W-1:0] s1_b_reg;
    logic              s1_cin_reg;
    logic              s1_sub_reg;
    logic              s1_daa_c_reg;
    logic [BYTE_W-1:0] s1_logic_reg;

    logic              s2_valid_reg;
    cmd_t              s2_cmd_reg;
    logic [BYTE_W-1:0] s2_a_reg;
    logic [FLAG_W-1:0] s2_f_reg;
    logic [BYTE_W-1:0] s2_sum_reg;
    logic              s2_sum_zero_reg;
    logic              s2_h_reg;
    logic              s2_c_reg;
    logic              s2_daa_c_reg;
    logic [BYTE_W-1:0] s2_logic_reg;
    logic              s2_logic_zero_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] acc_out_reg;
    logic [FLAG_W-1:0] flags_out_reg;

    cmd_t              s1_cmd_next;
    logic [BYTE_W-1:0] s1_b_next;
    logic              s1_cin_next;
    logic              s1_sub_next;
    logic              s1_daa_c_next;
    logic [BYTE_W-1:0] s1_logic_next;
    logic              daa_lo;
    logic              daa_hi;
    logic [BYTE_W-1:0] daa_adj;
    logic              fn_in;
    logic              fh_in;
    logic              fc_in;

    logic [BYTE_W:0]   sum_full;
    logic [4:0]        sum_half;
    logic [BYTE_W-1:0] s2_sum_next;
    logic              s2_h_next;
    logic              s2_c_next;

    logic [BYTE_W-1:0] acc_out_next;
    logic [FLAG_W-1:0] flags_out_next;
    logic              fz3;
    logic              fn3;
    logic              fc3;

    assign s3_en    = !out_valid_reg || !out_stall;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_stall = !s1_en;
    assign s3_load  = s3_en && s2_valid_reg;

    // Stage one: decode and prepare adder operands
    assign fn_in       = flags_in[FLAG_N];
    assign fh_in       = flags_in[FLAG_H];
    assign fc_in       = flags_in[FLAG_C];
    assign s1_cmd_next = cmd_t'(command);

    assign daa_lo  = fh_in || (!fn_in && (acc_in[3:0] > NIBBLE_MAX));
    assign daa_hi  = fc_in || (!fn_in && (acc_in > DAA_LIMIT));
    assign daa_adj = (daa_hi ? DAA_HI : '0) | (daa_lo ? DAA_LO : '0);

    always_comb
    begin
        logic [BYTE_W-1:0] b_raw;
        logic              c_raw;
        b_raw         = operand;
        c_raw         = 1'b0;
        s1_sub_next   = 1'b0;
        s1_daa_c_next = fc_in || daa_hi;
        case (s1_cmd_next)
            CMD_ADC:
            begin
                c_raw = fc_in;
            end
            CMD_SUB, CMD_CP:
            begin
                s1_sub_next = 1'b1;
            end
            CMD_SBC:
            begin
                c_raw       = fc_in;
                s1_sub_next = 1'b1;
            end
            CMD_INC:
            begin
                b_raw = ONE_BYTE;
            end
            CMD_DEC:
            begin
                b_raw       = ONE_BYTE;
                s1_sub_next = 1'b1;
            end
            CMD_DAA:
            begin
                b_raw       = daa_adj;
                s1_sub_next = fn_in;
            end
            default:
            begin
                b_raw = operand;
            end
        endcase
        s1_b_next   = s1_sub_next ? ~b_raw : b_raw;
        s1_cin_next = s1_sub_next ? !c_raw : c_raw;
        case (s1_cmd_next)
            CMD_XOR: s1_logic_next = acc_in ^ operand;
            CMD_OR:  s1_logic_next = acc_in | operand;
            default: s1_logic_next = acc_in & operand;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            s1_cmd_reg   <= s1_cmd_next;
            s1_a_reg     <= acc_in;
            s1_f_reg     <= flags_in;
            s1_b_reg     <= s1_b_next;
            s1_cin_reg   <= s1_cin_next;
            s1_sub_reg   <= s1_sub_next;
            s1_daa_c_reg <= s1_daa_c_next;
            s1_logic_reg <= s1_logic_next;
        end
    end

    // Stage two: shared adder with half and full carry
    assign sum_full    = {1'b0, s1_a_reg} + {1'b0, s1_b_reg} + {{BYTE_W{1'b0}}, s1_cin_reg};
    assign sum_half    = {1'b0, s1_a_reg[3:0]} + {1'b0, s1_b_reg[3:0]} + {4'b0, s1_cin_reg};
    assign s2_sum_next = sum_full[BYTE_W-1:0];
    assign s2_c_next   = s1_sub_reg ? !sum_full[BYTE_W] : sum_full[BYTE_W];
    assign s2_h_next   = s1_sub_reg ? !sum_half[4] : sum_half[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_cmd_reg        <= s1_cmd_reg;
            s2_a_reg          <= s1_a_reg;
            s2_f_reg          <= s1_f_reg;
            s2_sum_reg        <= s2_sum_next;
            s2_sum_zero_reg   <= (s2_sum_next == '0);
            s2_h_reg          <= s2_h_next;
            s2_c_reg          <= s2_c_next;
            s2_daa_c_reg      <= s1_daa_c_reg;
            s2_logic_reg      <= s1_logic_reg;
            s2_logic_zero_reg <= (s1_logic_reg == '0);
        end
    end

    // Stage three: select result and flags
    assign fz3 = s2_f_reg[FLAG_Z];
    assign fn3 = s2_f_reg[FLAG_N];
    assign fc3 = s2_f_reg[FLAG_C];

    always_comb
    begin
        case (s2_cmd_reg)
            CMD_ADD, CMD_ADC:
            begin
                acc_out_next   = s2_sum_reg;
                flags_out_next = {s2_sum_zero_reg, 1'b0, s2_h_reg, s2_c_reg};
            end
            CMD_SUB, CMD_SBC:
            begin
                acc_out_next   = s2_sum_reg;
                flags_out_next = {s2_sum_zero_reg, 1'b1, s2_h_reg, s2_c_reg};
            end
            CMD_CP:
            begin
                acc_out_next   = s2_a_reg;
                flags_out_next = {s2_sum_zero_reg, 1'b1, s2_h_reg, s2_c_reg};
            end
            CMD_AND:
            begin
                acc_out_next   = s2_logic_reg;
                flags_out_next = {s2_logic_zero_reg, 1'b0, 1'b1, 1'b0};
            end
            CMD_XOR, CMD_OR:
            begin
                acc_out_next   = s2_logic_reg;
                flags_out_next = {s2_logic_zero_reg, 1'b0, 1'b0, 1'b0};
            end
            CMD_INC:
            begin
                acc_out_next   = s2_sum_reg;
                flags_out_next = {s2_sum_zero_reg, 1'b0, s2_h_reg, fc3};
            end
            CMD_DEC:
            begin
                acc_out_next   = s2_sum_reg;
                flags_out_next = {s2_sum_zero_reg, 1'b1, s2_h_reg, fc3};
            end
            CMD_DAA:
            begin
                acc_out_next   = s2_sum_reg;
                flags_out_next = {s2_sum_zero_reg, fn3, 1'b0, s2_daa_c_reg};
            end
            CMD_RLCA:
            begin
                acc_out_next   = {s2_a_reg[BYTE_W-2:0], s2_a_reg[BYTE_W-1]};
                flags_out_next = {3'b000, s2_a_reg[BYTE_W-1]};
            end
            CMD_RRCA:
            begin
                acc_out_next   = {s2_a_reg[0], s2_a_reg[BYTE_W-1:1]};
                flags_out_next = {3'b000, s2_a_reg[0]};
            end
            CMD_RLA:
            begin
                acc_out_next   = {s2_a_reg[BYTE_W-2:0], fc3};
                flags_out_next = {3'b000, s2_a_reg[BYTE_W-1]};
            end
            CMD_RRA:
            begin
                acc_out_next   = {fc3, s2_a_reg[BYTE_W-1:1]};
                flags_out_next = {3'b000, s2_a_reg[0]};
            end
            CMD_CPL:
            begin
                acc_out_next   = ~s2_a_reg;
                flags_out_next = {fz3, 1'b1, 1'b1, fc3};
            end
            CMD_SCF:
            begin
                acc_out_next   = s2_a_reg;
                flags_out_next = {fz3, 1'b0, 1'b0, 1'b1};
            end
            CMD_CCF:
            begin
                acc_out_next   = s2_a_reg;
                flags_out_next = {fz3, 1'b0, 1'b0, !fc3};
            end
            default:
            begin
                acc_out_next   = s2_a_reg;
                flags_out_next = s2_f_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_en)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            acc_out_reg   <= acc_out_next;
            flags_out_reg <= flags_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign acc_out   = acc_out_reg;
    assign flags_out = flags_out_reg;

    `EBA_ASSERT_NOW(a_stall_needs_full_s1, in_stall, s1_valid_reg && s2_valid_reg && out_valid_reg)
    `EBA_ASSERT_NEXT(a_accept_lands_s1, in_valid && !in_stall, s1_valid_reg)
    `EBA_ASSERT_NEXT(a_s1_moves_to_s2, s1_valid_reg && s2_en, s2_valid_reg)
    `EBA_ASSERT_NEXT(a_scf_carry, s3_load && s2_cmd_reg == CMD_SCF, out_valid && flags_out[FLAG_C])

endmodule
